/* src/tis_pkg.sv */
// ----------------------------------------------------------------------------
// tis_pkg: shared types and constants of the transaction id tag scanner
// Field widths, limits, register map codes and the structs passed between
// the top level and the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tis_pkg;

  localparam int TIS_POS_W         = 16;
  localparam logic [TIS_POS_W-1:0] TIS_POS_LIMIT = 16'hFFFF;
  localparam int TIS_MAX_ID_BYTES  = 8;
  localparam int TIS_STAGE_CNT     = TIS_MAX_ID_BYTES + 1;
  localparam int TIS_LEFT_W        = 4;
  localparam int TIS_VAL_W         = 8 * TIS_MAX_ID_BYTES;

  // configuration port
  localparam int TIS_ADDR_W = 4;
  localparam int TIS_DATA_W = 32;
  localparam logic [1:0] REG_DEST_TAG  = 2'd0;
  localparam logic [1:0] REG_ORIG_TAG  = 2'd1;
  localparam logic [1:0] REG_BEGIN_TAG = 2'd2;

  localparam logic [7:0] DEST_TAG_RST  = 8'h49;
  localparam logic [7:0] ORIG_TAG_RST  = 8'h48;
  localparam logic [7:0] BEGIN_TAG_RST = 8'h62;

  typedef struct packed {
    logic [7:0] dest_tag;
    logic [7:0] orig_tag;
    logic [7:0] begin_tag;
  } tis_tags_t;

  // one field being gathered; stage index gives its age in bytes
  typedef struct packed {
    logic                  valid;
    logic                  is_dest;
    logic                  is_orig;
    logic                  begin_before;
    logic [TIS_LEFT_W-1:0] left;
    logic [TIS_POS_W-1:0]  start;
    logic [TIS_VAL_W-1:0]  value;
  } tis_stage_t;

  typedef struct packed {
    logic                 found;
    logic                 begin_before;
    logic [TIS_POS_W-1:0] start;
    logic [TIS_VAL_W-1:0] value;
  } tis_best_t;

  typedef struct packed {
    logic                 found;
    logic                 id_kind;
    logic [TIS_VAL_W-1:0] id_value;
    logic                 after_begin;
    logic                 too_long;
  } tis_result_t;

endpackage

`default_nettype wire

/* src/tis_if.sv */
// ----------------------------------------------------------------------------
// tis_in_if / tis_out_if: valid/ready channels of the scanner
// Byte channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tis_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        id_kind;
  logic [63:0] id_value;
  logic        after_begin;
  logic        too_long;

  modport source (output valid, output found, output id_kind, output id_value,
                  output after_begin, output too_long, input ready);
  modport sink   (input valid, input found, input id_kind, input id_value,
                  input after_begin, input too_long, output ready);
endinterface

`default_nettype wire

/* src/tis_scan_engine.sv */
// ----------------------------------------------------------------------------
// tis_scan_engine: per-byte field tracking
// Keeps a shift line of fields under way, one stage per byte of age, and the
// earliest complete destination and origin fields of the current message.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_scan_engine
  import tis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire tis_tags_t   tags,
  output tis_result_t      res
);

  tis_stage_t                st_r   [TIS_STAGE_CNT];
  tis_stage_t                st_nxt [TIS_STAGE_CNT];
  tis_stage_t                fed    [TIS_STAGE_CNT];
  logic [TIS_STAGE_CNT-1:0]  done_d;
  logic [TIS_STAGE_CNT-1:0]  done_o;
  tis_best_t                 best_d_r, best_d_nxt;
  tis_best_t                 best_o_r, best_o_nxt;
  tis_stage_t                cand_d, cand_o;
  logic                      cand_d_v, cand_o_v;
  logic [TIS_POS_W-1:0]      pos_r, pos_nxt;
  logic                      begin_r, begin_nxt;
  logic                      over;
  logic                      hit_d, hit_o;

  always_comb begin
    over  = (pos_r >= TIS_POS_LIMIT);
    hit_d = (data_byte == tags.dest_tag);
    hit_o = (data_byte == tags.orig_tag);

    // feed the byte to every field under way
    for (int k = 0; k < TIS_STAGE_CNT; k++) begin
      fed[k]    = st_r[k];
      done_d[k] = 1'b0;
      done_o[k] = 1'b0;
      if (st_r[k].valid) begin
        if (k == 0) begin
          if ((data_byte == 8'd0) || (data_byte > 8'(TIS_MAX_ID_BYTES))) begin
            fed[k].valid = 1'b0;
          end else begin
            fed[k].left = data_byte[TIS_LEFT_W-1:0];
          end
        end else begin
          fed[k].value = {st_r[k].value[TIS_VAL_W-9:0], data_byte};
          fed[k].left  = st_r[k].left - 1'b1;
          if (st_r[k].left == TIS_LEFT_W'(1)) begin
            done_d[k]    = st_r[k].is_dest;
            done_o[k]    = st_r[k].is_orig;
            fed[k].valid = 1'b0;
          end
        end
      end
    end

    // older stage started earlier: take the oldest completion
    cand_d   = fed[0];
    cand_o   = fed[0];
    cand_d_v = 1'b0;
    cand_o_v = 1'b0;
    for (int k = 0; k < TIS_STAGE_CNT; k++) begin
      if (done_d[k]) begin
        cand_d   = fed[k];
        cand_d_v = 1'b1;
      end
      if (done_o[k]) begin
        cand_o   = fed[k];
        cand_o_v = 1'b1;
      end
    end

    best_d_nxt = best_d_r;
    if (cand_d_v && (!best_d_r.found || (cand_d.start < best_d_r.start))) begin
      best_d_nxt.found        = 1'b1;
      best_d_nxt.start        = cand_d.start;
      best_d_nxt.value        = cand_d.value;
      best_d_nxt.begin_before = cand_d.begin_before;
    end
    best_o_nxt = best_o_r;
    if (cand_o_v && (!best_o_r.found || (cand_o.start < best_o_r.start))) begin
      best_o_nxt.found        = 1'b1;
      best_o_nxt.start        = cand_o.start;
      best_o_nxt.value        = cand_o.value;
      best_o_nxt.begin_before = cand_o.begin_before;
    end

    // advance the shift line, open a field on a tag byte
    st_nxt[0]              = '0;
    st_nxt[0].valid        = !over && (hit_d || hit_o);
    st_nxt[0].is_dest      = hit_d;
    st_nxt[0].is_orig      = hit_o;
    st_nxt[0].begin_before = begin_r;
    st_nxt[0].start        = pos_r;
    for (int k = 1; k < TIS_STAGE_CNT; k++) begin
      st_nxt[k] = fed[k-1];
    end

    begin_nxt = begin_r || (data_byte == tags.begin_tag);
    pos_nxt   = over ? pos_r : pos_r + 1'b1;

    res = '0;
    if (best_d_nxt.found) begin
      res.found    = 1'b1;
      res.id_value = best_d_nxt.value;
    end else if (best_o_nxt.found) begin
      res.found       = 1'b1;
      res.id_kind     = 1'b1;
      res.id_value    = best_o_nxt.value;
      res.after_begin = best_o_nxt.begin_before;
    end
    res.too_long = over;

    // end of message: drop all per-message state
    if (last) begin
      for (int k = 0; k < TIS_STAGE_CNT; k++) begin
        st_nxt[k].valid = 1'b0;
      end
      best_d_nxt.found = 1'b0;
      best_o_nxt.found = 1'b0;
      begin_nxt        = 1'b0;
      pos_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TIS_STAGE_CNT; k++) begin
        st_r[k] <= '0;
      end
      best_d_r <= '0;
      best_o_r <= '0;
      pos_r    <= '0;
      begin_r  <= 1'b0;
    end else if (step) begin
      for (int k = 0; k < TIS_STAGE_CNT; k++) begin
        st_r[k] <= st_nxt[k];
      end
      best_d_r <= best_d_nxt;
      best_o_r <= best_o_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
    end
  end

`ifndef SYNTHESIS
  // the oldest stage always finishes on the next byte
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r[TIS_STAGE_CNT-1].valid |-> st_r[TIS_STAGE_CNT-1].left == TIS_LEFT_W'(1))
    else $error("oldest field stage would outlive the window");

  assert property (@(posedge clk) disable iff (!rst_n)
    best_d_r.found |-> best_d_r.start < pos_r)
    else $error("destination field starts at or after current position");

  assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> (pos_r == '0) && !begin_r && !best_d_r.found && !best_o_r.found)
    else $error("message state not cleared after final byte");
`endif

endmodule

`default_nettype wire

/* src/transaction_id_tag_scanner_core.sv */
// ----------------------------------------------------------------------------
// transaction_id_tag_scanner_core: streaming transaction id field search
// Byte stream in, one result word per message out, APB tag registers.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock, back to back, unless a final byte
// waits for a busy result slot, and gives one result word per message: the
// final byte passes the input register, then its result the output register.
// Each byte is held in the input register, then folded into a nine-stage line
// of fields under way (one stage per byte of age, enough for a tag, a length
// and eight value bytes) and into the earliest destination and origin matches
// so far. A result waiting in the output register does not stop incoming bytes
// until the next final byte arrives. Tag registers live at byte addresses 0, 4
// and 8; the user keeps them changed only while no message is in flight, as the block does not enforce it.
`default_nettype none

module transaction_id_tag_scanner_core
  import tis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tis_in_if.sink                     in_chan,
  tis_out_if.source                  out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [TIS_ADDR_W-1:0] paddr,
  input  wire logic [TIS_DATA_W-1:0] pwdata,
  output logic      [TIS_DATA_W-1:0] prdata,
  output logic                       pready
);

  tis_tags_t   tags_r;
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        out_v_r;
  tis_result_t out_res_r;
  tis_result_t res;
  logic        step;
  logic        in_take;
  logic        cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tags_r.dest_tag  <= DEST_TAG_RST;
      tags_r.orig_tag  <= ORIG_TAG_RST;
      tags_r.begin_tag <= BEGIN_TAG_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEST_TAG:  tags_r.dest_tag  <= pwdata[7:0];
        REG_ORIG_TAG:  tags_r.orig_tag  <= pwdata[7:0];
        REG_BEGIN_TAG: tags_r.begin_tag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEST_TAG:  prdata = {24'd0, tags_r.dest_tag};
      REG_ORIG_TAG:  prdata = {24'd0, tags_r.orig_tag};
      REG_BEGIN_TAG: prdata = {24'd0, tags_r.begin_tag};
      default:       prdata = '0;
    endcase
  end

  // process the held byte unless it closes a message and the result slot is busy
  assign step           = in_v_r && (!in_last_r || !out_v_r || out_chan.ready);
  assign in_chan.ready  = !in_v_r || step;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.data_byte;
      in_last_r <= in_chan.last;
    end
  end

  tis_scan_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .tags      (tags_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.found       = out_res_r.found;
  assign out_chan.id_kind     = out_res_r.id_kind;
  assign out_chan.id_value    = out_res_r.id_value;
  assign out_chan.after_begin = out_res_r.after_begin;
  assign out_chan.too_long    = out_res_r.too_long;

endmodule

`default_nettype wire

/* test/transaction_id_tag_scanner_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transaction_id_tag_scanner_core_test: self-checking bench of the tag scanner
// Streams messages through the byte channel under several tag settings and
// idle patterns. A scoreboard predicts each per-message result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------

module transaction_id_tag_scanner_core_test
  import tis_pkg::*;
();

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 6;
  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SLOT_CNT      = TIS_MAX_ID_BYTES + 2;
  localparam int REG_SPARE_IDX = 3;
  localparam logic KIND_DEST   = 1'b0;
  localparam logic KIND_ORIG   = 1'b1;

  typedef struct {
    bit          valid;
    bit          is_dest;
    bit          is_orig;
    bit          have_len;
    bit          begin_before;
    int unsigned start;
    int unsigned left;
    logic [63:0] value;
  } field_slot_t;

  class tag_scan_scoreboard;
    logic [7:0]  dest_tag;
    logic [7:0]  orig_tag;
    logic [7:0]  begin_tag;
    int unsigned pos;
    bit          begin_seen;
    field_slot_t slots[SLOT_CNT];
    tis_best_t   best_dest;
    tis_best_t   best_orig;
    tis_result_t expected_q[$];
    int errors;
    int bytes_in;
    int results_checked;
    int dest_hits;
    int orig_hits;
    int misses;
    int long_hits;

    function new();
      dest_tag  = DEST_TAG_RST;
      orig_tag  = ORIG_TAG_RST;
      begin_tag = BEGIN_TAG_RST;
      clear_message();
    endfunction

    function void clear_message();
      pos        = 0;
      begin_seen = 0;
      best_dest  = '0;
      best_orig  = '0;
      foreach (slots[i]) slots[i] = '{default: 0};
    endfunction

    function void set_reg(int idx, logic [7:0] v);
      case (idx)
        REG_DEST_TAG:  dest_tag = v;
        REG_ORIG_TAG:  orig_tag = v;
        REG_BEGIN_TAG: begin_tag = v;
        default: ;
      endcase
    endfunction

    function tis_best_t take_earliest(tis_best_t cur, field_slot_t s);
      if (!cur.found || s.start < cur.start) begin
        cur.found        = 1'b1;
        cur.start        = s.start[TIS_POS_W-1:0];
        cur.value        = s.value;
        cur.begin_before = s.begin_before;
      end
      return cur;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      bit          over;
      bit          placed;
      tis_result_t want;
      over   = (pos >= TIS_POS_LIMIT);
      placed = 0;
      bytes_in++;
      // advance fields under way
      foreach (slots[i]) begin
        if (!slots[i].valid) continue;
        if (!slots[i].have_len) begin
          if (b < 1 || b > TIS_MAX_ID_BYTES) begin
            slots[i].valid = 0;
          end else begin
            slots[i].have_len = 1;
            slots[i].left     = b;
          end
        end else begin
          slots[i].value = {slots[i].value[55:0], b};
          slots[i].left--;
          if (slots[i].left == 0) begin
            if (slots[i].is_dest) best_dest = take_earliest(best_dest, slots[i]);
            if (slots[i].is_orig) best_orig = take_earliest(best_orig, slots[i]);
            slots[i].valid = 0;
          end
        end
      end
      // open a field on a tag byte, unless past the position limit
      if (!over && (b == dest_tag || b == orig_tag)) begin
        foreach (slots[i]) begin
          if (!placed && !slots[i].valid) begin
            slots[i] = '{valid: 1, is_dest: (b == dest_tag), is_orig: (b == orig_tag),
                         have_len: 0, begin_before: begin_seen, start: pos,
                         left: 0, value: '0};
            placed = 1;
          end
        end
      end
      if (b == begin_tag) begin_seen = 1;
      if (!over) pos++;
      if (!last) return;

      want = '0;
      if (best_dest.found) begin
        want.found    = 1'b1;
        want.id_kind  = KIND_DEST;
        want.id_value = best_dest.value;
        dest_hits++;
      end else if (best_orig.found) begin
        want.found       = 1'b1;
        want.id_kind     = KIND_ORIG;
        want.id_value    = best_orig.value;
        want.after_begin = best_orig.begin_before;
        orig_hits++;
      end else begin
        misses++;
      end
      want.too_long = over;
      if (over) long_hits++;
      expected_q.push_back(want);
      clear_message();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(tis_result_t got);
      tis_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("found", 64'(want.found), 64'(got.found));
      check_field("id_kind", 64'(want.id_kind), 64'(got.id_kind));
      check_field("id_value", want.id_value, got.id_value);
      check_field("after_begin", 64'(want.after_begin), 64'(got.after_begin));
      check_field("too_long", 64'(want.too_long), 64'(got.too_long));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [TIS_ADDR_W-1:0] paddr;
  logic [TIS_DATA_W-1:0] pwdata;
  logic [TIS_DATA_W-1:0] prdata;
  logic pready;

  tis_in_if  in_chan ();
  tis_out_if out_chan ();

  transaction_id_tag_scanner_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tag_scan_scoreboard score;
  logic [7:0] msg_q[$];
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int messages_sent = 0;

  always #CLK_HALF clk = ~clk;

  initial begin
    #RUN_LIMIT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin : result_watch
    tis_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.found       = out_chan.found;
      got.id_kind     = out_chan.id_kind;
      got.id_value    = out_chan.id_value;
      got.after_begin = out_chan.after_begin;
      got.too_long    = out_chan.too_long;
      score.check_result(got);
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last      <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    score.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_message();
    int n;
    n = msg_q.size();
    for (int i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
    messages_sent++;
  endtask

  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (score.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIS_ADDR_W'(idx * 4);
    pwdata  <= TIS_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    score.set_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_tags(logic [7:0] dest, logic [7:0] orig, logic [7:0] bgn);
    write_reg(REG_DEST_TAG, dest);
    write_reg(REG_ORIG_TAG, orig);
    write_reg(REG_BEGIN_TAG, bgn);
  endtask

  function automatic logic [7:0] any_tag();
    case ($urandom_range(3))
      0: return score.dest_tag;
      1: return score.orig_tag;
      2: return score.begin_tag;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed fields with random content; some noise, bad lengths
  // and fields cut off by the end of the message
  function automatic void build_message(int unsigned max_len);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    msg_q.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, max_len);
    if ($urandom_range(9) == 0) begin
      repeat (target) msg_q.push_back(8'($urandom_range(255)));
      return;
    end
    while (msg_q.size() < target) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1: msg_q.push_back(8'($urandom_range(255)));
        2: msg_q.push_back(score.begin_tag);
        default: begin
          if (pick < 5)      msg_q.push_back(score.dest_tag);
          else if (pick < 8) msg_q.push_back(score.orig_tag);
          else               msg_q.push_back(any_tag());
          if ($urandom_range(7) == 0)
            len = $urandom_range(1) ? 0 : $urandom_range(TIS_MAX_ID_BYTES + 1, 255);
          else
            len = $urandom_range(1, TIS_MAX_ID_BYTES);
          msg_q.push_back(8'(len));
          if (len <= TIS_MAX_ID_BYTES) begin
            repeat (len)
              msg_q.push_back($urandom_range(3) == 0 ? any_tag() : 8'($urandom_range(255)));
          end
        end
      endcase
    end
    while (msg_q.size() > target) void'(msg_q.pop_back());
  endfunction

  task automatic run_random(int budget, int unsigned max_len);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_message(max_len);
      sent += msg_q.size();
      send_message();
    end
  endtask

  initial begin
    score = new();
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_chan.valid     = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last      = 1'b0;
    out_chan.ready    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed messages at the reset tag values, no idling
    msg_q = '{DEST_TAG_RST};
    send_message();
    msg_q = '{ORIG_TAG_RST, 8'h01};
    send_message();
    msg_q = '{BEGIN_TAG_RST, ORIG_TAG_RST, 8'h01, 8'h00};
    send_message();
    msg_q = '{ORIG_TAG_RST, 8'h09, DEST_TAG_RST, 8'h00, DEST_TAG_RST, 8'h01, 8'hFF};
    send_message();
    msg_q = '{DEST_TAG_RST, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg_q = '{DEST_TAG_RST, 8'h02, 8'hAA};
    send_message();
    run_random(120, 24);

    wait_drain();
    set_tags(8'h00, 8'hFF, 8'h00);
    in_idle_pct = 61;
    run_random(120, 24);

    wait_drain();
    set_tags(8'hFF, 8'h00, 8'h00);
    in_idle_pct   = 0;
    out_stall_pct = 61;
    run_random(120, 24);

    // one tag byte for both kinds; the spare register index is ignored
    wait_drain();
    set_tags(8'h3C, 8'h3C, 8'h3C);
    write_reg(REG_SPARE_IDX, 8'hA5);
    in_idle_pct   = 13;
    out_stall_pct = 13;
    run_random(120, 24);

    // hold the result side long enough that the input backs up
    wait_drain();
    set_tags(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    in_idle_pct   = 0;
    out_stall_pct = 0;
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    @(negedge clk);
    run_random(90, 6);
    wait_drain();
    run_random(60, 20);

    // overlong message: a field straddles the limit, a later tag is ignored
    wait_drain();
    set_tags(DEST_TAG_RST, ORIG_TAG_RST, BEGIN_TAG_RST);
    msg_q.delete();
    repeat (int'(TIS_POS_LIMIT) - 2) msg_q.push_back(8'h00);
    msg_q.push_back(ORIG_TAG_RST);
    msg_q.push_back(8'h02);
    msg_q.push_back(8'hAB);
    msg_q.push_back(8'hCD);
    msg_q.push_back(DEST_TAG_RST);
    msg_q.push_back(8'h01);
    msg_q.push_back(8'h77);
    send_message();

    wait_drain();
    $display("Covered %0d messages (%0d bytes) over six tag settings and idle patterns.",
             messages_sent, score.bytes_in);
    $display("Results: %0d checked, %0d dest, %0d orig, %0d not found, %0d too long.",
             score.results_checked, score.dest_hits, score.orig_hits, score.misses,
             score.long_hits);
    if (score.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
